// File: sv/search_candidate_stack_with_dedupe_defines.svh
// Assertion macros shared by the candidate stack RTL.
`ifndef SEARCH_CANDIDATE_STACK_WITH_DEDUPE_DEFINES_SVH
`define SEARCH_CANDIDATE_STACK_WITH_DEDUPE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/scsd_pkg.sv
// Shared constants, codes and types of the candidate stack.
package scsd_pkg;

   localparam int SLOTS    = 16;
   localparam int KEY_W    = 256;
   localparam int ROUTE_W  = 64;
   localparam int ASKED_W  = 4;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 1;
   localparam int PTR_W    = $clog2(SLOTS);
   localparam int COUNT_W  = $clog2(SLOTS + 1);

   localparam int REQ_DATA_W = ((KEY_W + ROUTE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_W + ROUTE_W + ASKED_W + 7) / 8) * 8;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_NEXT = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ASKED    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RETURNED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // Stack cell operations
   localparam int STK_OP_W = 2;
   localparam logic [STK_OP_W-1:0] STK_HOLD = 2'd0;
   localparam logic [STK_OP_W-1:0] STK_PREV = 2'd1;
   localparam logic [STK_OP_W-1:0] STK_NEXT = 2'd2;

   typedef struct packed {
      logic active;
      logic hit;
      logic stop;
   } scsd_token_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [ROUTE_W-1:0] route;
   } scsd_entry_type;

endpackage

// File: sv/search_candidate_stack_with_dedupe.sv
// Candidate stack with asked-ring dedupe for one lookup: top level.
//
// Requests arrive on req_* (tuser = command, tdata = 256-bit key and route).
// An add is compared against every asked-ring slot by a token that walks a
// chain of SLOTS ring cells, one cell per cycle; the dedupe result is ready
// when the token leaves the last cell, and the add's response is registered
// in S_DONE. A next request pops the top stack cell, records its key in the
// ring cell at the ring pointer and registers its response in S_POP; on an
// empty stack it pops nothing and responds with the empty status.
// The stack is a chain of cells that shift down on push and up on pop; a
// push onto a full stack overwrites the top cell only.
// One transaction is in progress at a time; a new request is taken while the
// previous response still waits in the output register.
// When rsp_tready is low, the finished result is held in the output
// register and the block stalls before writing the next one.
// Reset empties the stack, clears the ring pointer and marks every ring slot
// as all-zero at once (no clearing sweep).
`include "search_candidate_stack_with_dedupe_defines.svh"

module search_candidate_stack_with_dedupe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // key_word0, key_word1, key_word2, key_word3, route_in
   input  logic [scsd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic [scsd_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_key0, out_key1, out_key2, out_key3, route_out, asked_slot, zero pad
   output logic [scsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [scsd_pkg::STATUS_W-1:0]       rsp_tuser
);
   import scsd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;
   localparam logic [1:0] S_POP  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [KEY_W-1:0]     add_key_ff, add_key_in;
   logic [ROUTE_W-1:0]   add_route_ff, add_route_in;
   logic                 start_ff, start_in;
   logic                 hit_ff, hit_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [ROUTE_W-1:0]   rsp_route_ff, rsp_route_in;
   logic [ASKED_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                 req_accept;
   logic                 out_free;
   logic                 stack_empty;
   logic                 stack_full;
   logic                 do_push;
   logic                 do_pop;
   logic [STK_OP_W-1:0]  stk_op_all;
   logic [STK_OP_W-1:0]  stk_op_head;

   scsd_token_type       tok_chain [0:SLOTS];
   scsd_entry_type       entries   [0:SLOTS-1];
   scsd_entry_type       new_entry;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == COUNT_W'(SLOTS));
   assign do_push     = (state_ff == S_DONE) && out_free && !hit_ff;
   assign do_pop      = (state_ff == S_POP) && out_free && !stack_empty;

   assign new_entry.key   = add_key_ff;
   assign new_entry.route = add_route_ff;

   // launch the scan token into the first ring cell
   assign tok_chain[0] = '{active: start_ff, hit: 1'b0, stop: 1'b0};

   // pop shifts every cell up; push shifts down unless full, when only the
   // top cell is overwritten
   always_comb begin
      priority if (do_pop) begin
         stk_op_all = STK_NEXT;
      end else if (do_push && !stack_full) begin
         stk_op_all = STK_PREV;
      end else begin
         stk_op_all = STK_HOLD;
      end
      stk_op_head = do_push ? STK_PREV : stk_op_all;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cells
      logic [STK_OP_W-1:0] cell_op;
      scsd_entry_type      below_entry;

      assign cell_op = (i == 0) ? stk_op_head : stk_op_all;
      if (i == SLOTS - 1) begin : g_last
         assign below_entry = entries[i];
      end else begin : g_mid
         assign below_entry = entries[i + 1];
      end

      scsd_ring_cell u_ring (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (do_pop && (ptr_ff == PTR_W'(i))),
         .wr_key   (entries[0].key),
         .at_ptr   (ptr_ff == PTR_W'(i)),
         .scan_key (add_key_ff),
         .prev_tok (tok_chain[i]),
         .this_tok (tok_chain[i + 1])
      );

      scsd_stack_cell u_stack (
         .clock      (clock),
         .op         (cell_op),
         .prev_entry ((i == 0) ? new_entry : entries[(i == 0) ? 0 : i - 1]),
         .next_entry (below_entry),
         .entry      (entries[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      add_key_in    = add_key_ff;
      add_route_in  = add_route_ff;
      start_in      = 1'b0;
      hit_in        = hit_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_route_in  = rsp_route_ff;
      rsp_slot_in   = rsp_slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               add_key_in   = req_tdata[KEY_W-1:0];
               add_route_in = req_tdata[KEY_W +: ROUTE_W];
               if (req_tuser == CMD_ADD) begin
                  start_in = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_SCAN: begin
            // wait for the token to leave the last ring cell
            if (tok_chain[SLOTS].active) begin
               hit_in   = tok_chain[SLOTS].hit;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hit_ff ? ST_ASKED : ST_ADDED;
               rsp_key_in    = '0;
               rsp_route_in  = '0;
               rsp_slot_in   = '0;
               if (!hit_ff && !stack_full) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (stack_empty) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_key_in    = '0;
                  rsp_route_in  = '0;
                  rsp_slot_in   = '0;
               end else begin
                  rsp_status_in = ST_RETURNED;
                  rsp_key_in    = entries[0].key;
                  rsp_route_in  = entries[0].route;
                  rsp_slot_in   = ASKED_W'(ptr_ff);
                  count_in      = count_ff - COUNT_W'(1);
                  ptr_in        = (ptr_ff == PTR_W'(SLOTS - 1)) ? '0
                                                               : ptr_ff + PTR_W'(1);
               end
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      add_key_ff    <= add_key_in;
      add_route_ff  <= add_route_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_route_ff  <= rsp_route_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_slot_ff, rsp_route_ff, rsp_key_ff});

   `SCSD_ASSERT_SAME(a_token_only_in_scan, clock, reset, tok_chain[SLOTS].active, state_ff == S_SCAN, "scan token left the ring outside a scan")
   `SCSD_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= COUNT_W'(SLOTS), "stack count above capacity")
   `SCSD_ASSERT_NEXT(a_reject_keeps_count, clock, reset, (state_ff == S_DONE) && out_free && hit_ff, count_ff == $past(count_ff), "rejected add changed the stack count")
   `SCSD_ASSERT_NEXT(a_pop_moves_ptr, clock, reset, do_pop, (ptr_ff != $past(ptr_ff)) && rsp_tvalid && (rsp_tuser == ST_RETURNED), "pop did not advance the ring or respond")

endmodule

// File: sv/scsd_ring_cell.sv
// One asked-ring slot: stored key plus the compare stage of the scan chain.
module scsd_ring_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [scsd_pkg::KEY_W-1:0]    wr_key,
   input  logic                          at_ptr,
   input  logic [scsd_pkg::KEY_W-1:0]    scan_key,
   input  scsd_pkg::scsd_token_type      prev_tok,
   output scsd_pkg::scsd_token_type      this_tok
);
   import scsd_pkg::*;

   logic               valid_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   slot_key;
   logic               key_eq;
   logic               key_zero;
   scsd_token_type     tok_ff;
   scsd_token_type     tok_in;

   // an unwritten slot reads as an all-zero key
   assign slot_key = valid_ff ? key_ff : '0;
   assign key_eq   = (slot_key == scan_key);
   assign key_zero = (slot_key == '0);

   always_comb begin
      tok_in.active = prev_tok.active;
      tok_in.hit    = prev_tok.hit | (~prev_tok.stop & key_eq);
      tok_in.stop   = prev_tok.stop | (at_ptr & key_zero);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_ff <= wr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign this_tok = tok_ff;

endmodule

// File: sv/scsd_stack_cell.sv
// One candidate stack entry: holds, or takes the entry of a neighbour.
module scsd_stack_cell (
   input  logic                            clock,
   input  logic [scsd_pkg::STK_OP_W-1:0]   op,
   input  scsd_pkg::scsd_entry_type        prev_entry,
   input  scsd_pkg::scsd_entry_type        next_entry,
   output scsd_pkg::scsd_entry_type        entry
);
   import scsd_pkg::*;

   scsd_entry_type entry_ff;
   scsd_entry_type entry_in;

   always_comb begin
      unique case (op)
         STK_PREV: entry_in = prev_entry;
         STK_NEXT: entry_in = next_entry;
         default:  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
